/* rtl/crc24_pkg.sv */
// ----------------------------------------------------------------------------
// CRC-24 byte engine package
// Widths, reset values and configuration register indexes shared by the
// CRC-24 byte engine.
// ----------------------------------------------------------------------------
package crc24_pkg;

  localparam int unsigned CRC_W      = 24;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CRC_W-1:0] INIT_RESET = 24'hB704CE;
  localparam logic [CRC_W-1:0] POLY_RESET = 24'h864CFB;
  localparam logic [CRC_W-1:0] CRC_MASK   = 24'hFFFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INITIAL_VALUE = 2'd0,
    REG_POLYNOMIAL    = 2'd1,
    REG_REFLECTED     = 2'd2,
    REG_INVERT_OUTPUT = 2'd3
  } cfg_reg_t;

endpackage

/* rtl/crc24_configurable_byte_engine.sv */
// ----------------------------------------------------------------------------
// CRC-24 configurable byte engine
// A last byte waits in the input register; its CRC is then registered onto
// crc_value and crc_valid once the result register is free. Throughput: one byte
// per cycle while data_stall is low, set by the input-to-CRC eight-bit XOR fold.
// Reset loads the default configuration and the default initial value into
// the CRC register and empties both pipeline registers.
// ----------------------------------------------------------------------------
module crc24_configurable_byte_engine (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [crc24_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [crc24_pkg::CRC_W-1:0]           cfg_data,
  input  logic                                  data_valid,
  output logic                                  data_stall,
  input  logic [crc24_pkg::BYTE_W-1:0]          data_byte,
  input  logic                                  last_byte,
  output logic                                  crc_valid,
  input  logic                                  crc_stall,
  output logic [crc24_pkg::CRC_W-1:0]           crc_value
);

  logic [crc24_pkg::CRC_W-1:0]  initial_value;
  logic [crc24_pkg::CRC_W-1:0]  polynomial;
  logic                         reflected;
  logic                         invert_output;

  logic [crc24_pkg::CRC_W-1:0]  crc_register;
  logic [crc24_pkg::CRC_W-1:0]  crc_register_next;
  logic [crc24_pkg::CRC_W-1:0]  fold_result;
  logic [crc24_pkg::CRC_W-1:0]  reversed_poly;

  logic                         hold_valid;
  logic [crc24_pkg::BYTE_W-1:0] hold_byte;
  logic                         hold_last;
  logic                         advance;
  logic                         data_accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_value <= crc24_pkg::INIT_RESET;
      polynomial    <= crc24_pkg::POLY_RESET;
      reflected     <= 1'b0;
      invert_output <= 1'b0;
    end else if (cfg_write) begin
      case (crc24_pkg::cfg_reg_t'(cfg_index))
        crc24_pkg::REG_INITIAL_VALUE: initial_value <= cfg_data;
        crc24_pkg::REG_POLYNOMIAL:    polynomial    <= cfg_data;
        crc24_pkg::REG_REFLECTED:     reflected     <= cfg_data[0];
        crc24_pkg::REG_INVERT_OUTPUT: invert_output <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // A held last byte may only move on once the result register is free.
  assign advance     = hold_valid && !(hold_last && crc_valid && crc_stall);
  assign data_stall  = hold_valid && !advance;
  assign data_accept = data_valid && !data_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (data_accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_accept) begin
      hold_byte <= data_byte;
      hold_last <= last_byte;
    end
  end

  always_comb begin
    for (int i = 0; i < crc24_pkg::CRC_W; i++) begin
      reversed_poly[i] = polynomial[crc24_pkg::CRC_W-1-i];
    end
  end

  always_comb begin
    logic [crc24_pkg::CRC_W-1:0] work;
    if (reflected) begin
      work = crc_register ^ {{(crc24_pkg::CRC_W-crc24_pkg::BYTE_W){1'b0}}, hold_byte};
      for (int i = 0; i < crc24_pkg::BYTE_W; i++) begin
        work = work[0] ? ((work >> 1) ^ reversed_poly) : (work >> 1);
      end
    end else begin
      work = crc_register ^ {hold_byte, {(crc24_pkg::CRC_W-crc24_pkg::BYTE_W){1'b0}}};
      for (int i = 0; i < crc24_pkg::BYTE_W; i++) begin
        work = work[crc24_pkg::CRC_W-1] ? ((work << 1) ^ polynomial) : (work << 1);
      end
    end
    fold_result = work;
  end

  always_comb begin
    crc_register_next = crc_register;
    if (advance) begin
      crc_register_next = hold_last ? initial_value : fold_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_register <= crc24_pkg::INIT_RESET;
    end else begin
      crc_register <= crc_register_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_valid <= 1'b0;
    end else if (advance && hold_last) begin
      crc_valid <= 1'b1;
    end else if (!crc_stall) begin
      crc_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_last) begin
      crc_value <= invert_output ? (fold_result ^ crc24_pkg::CRC_MASK) : fold_result;
    end
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// CRC-24 configurable byte engine testbench
// Streams message bytes into the engine under several register settings.
// Settings include normal and reflected order, inverted output, and zero and
// all-ones polynomials. Settings are also changed in the middle of a message.
// A bit-serial predictor works out each message CRC. Every CRC transfer is
// compared with the oldest prediction. The input channel idles and the result
// channel stalls at random.
module tb;

  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_BYTES  = 800;
  localparam logic [3:0] ALL_REGS = 4'hF;

  logic                          clk        = 1'b0;
  logic                          rst        = 1'b1;
  logic                          cfg_write  = 1'b0;
  crc24_pkg::cfg_reg_t           cfg_index  = crc24_pkg::REG_INITIAL_VALUE;
  logic [crc24_pkg::CRC_W-1:0]   cfg_data   = '0;
  logic                          data_valid = 1'b0;
  logic                          data_stall;
  logic [crc24_pkg::BYTE_W-1:0]  data_byte  = '0;
  logic                          last_byte  = 1'b0;
  logic                          crc_valid;
  logic                          crc_stall  = 1'b0;
  logic [crc24_pkg::CRC_W-1:0]   crc_value;

  logic [crc24_pkg::CRC_W-1:0]   model_init = crc24_pkg::INIT_RESET;
  logic [crc24_pkg::CRC_W-1:0]   model_poly = crc24_pkg::POLY_RESET;
  logic                          model_refl = 1'b0;
  logic                          model_inv  = 1'b0;
  logic [crc24_pkg::CRC_W-1:0]   running_crc = crc24_pkg::INIT_RESET;
  logic [crc24_pkg::CRC_W-1:0]   crc_expected[$];

  bit gaps_on  = 1'b0;
  bit stalls_on = 1'b0;
  int n_bytes;
  int n_crcs_checked;
  int n_errors;
  int n_setting_changes;

  crc24_configurable_byte_engine u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .crc_valid  (crc_valid),
    .crc_stall  (crc_stall),
    .crc_value  (crc_value)
  );

  always #6 clk = ~clk;

  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [crc24_pkg::CRC_W-1:0] fold_crc_byte(
      logic [crc24_pkg::CRC_W-1:0] crc, logic [crc24_pkg::BYTE_W-1:0] b);
    logic [crc24_pkg::CRC_W-1:0] rev_poly;
    int i;
    for (i = 0; i < crc24_pkg::CRC_W; i++) rev_poly[i] = model_poly[crc24_pkg::CRC_W-1-i];
    if (model_refl) begin
      crc ^= {16'h0, b};
      for (i = 0; i < 8; i++) crc = crc[0] ? ((crc >> 1) ^ rev_poly) : (crc >> 1);
    end else begin
      crc ^= {b, 16'h0};
      for (i = 0; i < 8; i++) begin
        crc = crc[crc24_pkg::CRC_W-1] ? ((crc << 1) ^ model_poly) : (crc << 1);
      end
    end
    return crc;
  endfunction

  function automatic logic [crc24_pkg::CRC_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return crc24_pkg::CRC_MASK;
      2: return crc24_pkg::POLY_RESET;
      default: return crc24_pkg::CRC_W'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [crc24_pkg::BYTE_W-1:0] b, input logic last);
    int gap;
    gap = (gaps_on && $urandom_range(0, 1) == 1) ? idle_len() : 0;
    repeat (gap) begin
      data_valid <= 1'b0;
      @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= last;
    @(posedge clk);
    while (data_stall) @(posedge clk);
    n_bytes++;
    running_crc = fold_crc_byte(running_crc, b);
    if (last) begin
      crc_expected.push_back(model_inv ? ~running_crc : running_crc);
      running_crc = model_init;
    end
  endtask

  // Stops sending and lets the engine finish every CRC it still owes.
  task automatic drain_results();
    data_valid <= 1'b0;
    while (crc_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [3:0] sel,
                            input logic [crc24_pkg::CRC_W-1:0] init,
                            input logic [crc24_pkg::CRC_W-1:0] poly, input logic refl,
                            input logic inv);
    int i;
    drain_results();
    for (i = 0; i < 4; i++) begin
      if (sel[i]) begin
        cfg_write <= 1'b1;
        cfg_index <= crc24_pkg::cfg_reg_t'(i);
        case (crc24_pkg::cfg_reg_t'(i))
          crc24_pkg::REG_INITIAL_VALUE: cfg_data <= init;
          crc24_pkg::REG_POLYNOMIAL:    cfg_data <= poly;
          crc24_pkg::REG_REFLECTED:     cfg_data <= {23'($urandom), refl};
          default:                      cfg_data <= {23'($urandom), inv};
        endcase
        @(posedge clk);
        case (crc24_pkg::cfg_reg_t'(i))
          crc24_pkg::REG_INITIAL_VALUE: model_init = init;
          crc24_pkg::REG_POLYNOMIAL:    model_poly = poly;
          crc24_pkg::REG_REFLECTED:     model_refl = refl;
          default:                      model_inv  = inv;
        endcase
      end
    end
    cfg_write <= 1'b0;
    n_setting_changes++;
  endtask

  task automatic test_defaults();
    int k;
    for (k = 0; k < 9; k++) send_byte(crc24_pkg::BYTE_W'(8'h31 + k), k == 8);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_directed_settings();
    write_regs(ALL_REGS, '0, crc24_pkg::CRC_MASK, 1'b1, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b1);
    write_regs(ALL_REGS, crc24_pkg::CRC_MASK, '0, 1'b0, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    // A new polynomial, order and start value arrive between two bytes of one
    // message; only the next message starts from the new value.
    send_byte(8'h12, 1'b0);
    write_regs(ALL_REGS, 24'h123456, crc24_pkg::POLY_RESET, 1'b1, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(8'h56, 1'b1);
  endtask

  task automatic test_random_messages();
    int sent_start;
    int phase;
    int msgs;
    int len;
    int k;
    sent_start = n_bytes;
    phase = 0;
    while (n_bytes - sent_start < RANDOM_BYTES) begin
      gaps_on   = (phase % 4 != 1) && ($urandom_range(0, 3) != 0);
      stalls_on = (phase % 4 != 1) && ($urandom_range(0, 3) != 0);
      write_regs(ALL_REGS, pick_word(), pick_word(), 1'($urandom), 1'($urandom));
      msgs = $urandom_range(5, 12);
      repeat (msgs) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
          if (k != 0 && $urandom_range(0, 39) == 0) begin
            write_regs(4'($urandom), pick_word(), pick_word(), 1'($urandom),
                       1'($urandom));
          end
          send_byte(crc24_pkg::BYTE_W'($urandom), k == len - 1);
        end
        if (phase == 2 || $urandom_range(0, 29) == 0) drain_results();
      end
      phase++;
    end
  endtask

  initial begin
    forever begin
      int len;
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 3) == 0) begin
        len = idle_len();
        crc_stall <= 1'b1;
        repeat (len) @(posedge clk);
        crc_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && crc_valid && !crc_stall) begin
      if (crc_expected.size() == 0) begin
        $error("crc_value: no CRC expected, actual %06h", crc_value);
        n_errors++;
      end else begin
        if (crc_value !== crc_expected[0]) begin
          $error("crc_value: expected %06h, actual %06h", crc_expected[0], crc_value);
          n_errors++;
        end
        void'(crc_expected.pop_front());
        n_crcs_checked++;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_directed_settings();
    test_random_messages();
    gaps_on = 1'b0;
    drain_results();
    $display("Sent %0d bytes and checked %0d CRCs over %0d setting changes,",
             n_bytes, n_crcs_checked, n_setting_changes);
    $display("in both bit orders, with and without inversion and idle cycles.");
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
